// File: src/bltf_pkg.sv
// ----------------------------------------------------------------------------
// bltf_pkg - backlight timeout/fade controller shared definitions
// Widths, constants, codes and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bltf_pkg;

  // Fade and level scaling constants
  localparam int FADE_STEPS = 50;
  localparam int FULL_LEVEL = 8499;
  localparam int PCT_MAX    = 100;

  // Field widths
  localparam int LEVEL_W   = 14;
  localparam int PCT_W     = 7;
  localparam int TICKS_W   = 16;
  localparam int ELAPSED_W = 10;
  localparam int MODE_W    = 2;

  // Derived widths
  localparam int PASS_W    = $clog2(FADE_STEPS + 1);
  localparam int FSTEP_W   = $clog2(FULL_LEVEL / FADE_STEPS + 1);
  localparam int DIV_CNT_W = $clog2(LEVEL_W);

  // level / fade steps as a reciprocal multiply, exact for every level up to
  // full level: step = (level * FADE_RECIP) >> FADE_SHIFT
  localparam int FADE_SHIFT  = 18;
  localparam int FADE_RECIP  = ((1 << FADE_SHIFT) + FADE_STEPS - 1) / FADE_STEPS;
  localparam int FADE_PROD_W = FADE_SHIFT + FSTEP_W;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_ON   = 1'b1
  } item_cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_FADE = 2'd2
  } mode_t;

  // Operand selection for the shared divider
  typedef enum logic [1:0] {
    DIV_PCT  = 2'd0,  // 100 / pct
    DIV_LVL  = 2'd1   // full level / (100 / pct)
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    div_sel_t div_sel;
    logic     commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic  on_req;
    logic  pct_zero;
    logic  div_done;
    logic  out_free;
  } ctl_sts_t;

endpackage

`default_nettype wire

// File: src/bltf_if.sv
// ----------------------------------------------------------------------------
// bltf_if - item channels of the backlight controller
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface bltf_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic [bltf_pkg::PCT_W-1:0]       percent;
  logic [bltf_pkg::TICKS_W-1:0]     on_ticks;
  logic [bltf_pkg::ELAPSED_W-1:0]   elapsed_ticks;

  modport source (
    output valid, command, percent, on_ticks, elapsed_ticks,
    input  ready
  );
  modport sink (
    input  valid, command, percent, on_ticks, elapsed_ticks,
    output ready
  );
endinterface

interface bltf_out_if;
  logic                             valid;
  logic                             ready;
  logic [bltf_pkg::LEVEL_W-1:0]     pwm_level;
  logic [bltf_pkg::MODE_W-1:0]      mode;

  modport source (
    output valid, pwm_level, mode,
    input  ready
  );
  modport sink (
    input  valid, pwm_level, mode,
    output ready
  );
endinterface

`default_nettype wire

// File: src/bltf_div.sv
// ----------------------------------------------------------------------------
// bltf_div - shared restoring divider
// One quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
`default_nettype none

module bltf_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [bltf_pkg::LEVEL_W-1:0]  dividend,
  input  wire logic [bltf_pkg::PCT_W-1:0]    divisor,
  output logic      [bltf_pkg::LEVEL_W-1:0]  quotient,
  output logic                               done
);

  logic                             busy_r;
  logic                             done_r;
  logic [bltf_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [bltf_pkg::PCT_W-1:0]       rem_r;
  logic [bltf_pkg::PCT_W-1:0]       rem_nxt;
  logic [bltf_pkg::LEVEL_W-1:0]     quo_r;
  logic [bltf_pkg::PCT_W-1:0]       dvs_r;
  logic [bltf_pkg::PCT_W:0]         trial;
  logic [bltf_pkg::PCT_W:0]         diff;
  logic                             fits;
  logic                             last;

  // bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, quo_r[bltf_pkg::LEVEL_W-1]};
    fits    = (trial >= {1'b0, dvs_r});
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = fits ? diff[bltf_pkg::PCT_W-1:0] : trial[bltf_pkg::PCT_W-1:0];
    last    = (cnt_r == bltf_pkg::DIV_CNT_W'(bltf_pkg::LEVEL_W - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[bltf_pkg::LEVEL_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

// File: src/bltf_dp.sv
// ----------------------------------------------------------------------------
// bltf_dp - backlight controller datapath
// Item capture, light state, shared divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bltf_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bltf_pkg::ctl_cmd_t              cmd,
  output bltf_pkg::ctl_sts_t                   sts,
  input  wire logic                            in_command,
  input  wire logic [bltf_pkg::PCT_W-1:0]      in_percent,
  input  wire logic [bltf_pkg::TICKS_W-1:0]    in_on_ticks,
  input  wire logic [bltf_pkg::ELAPSED_W-1:0]  in_elapsed_ticks,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic      [bltf_pkg::LEVEL_W-1:0]    out_pwm_level,
  output logic      [bltf_pkg::MODE_W-1:0]     out_mode
);

  // captured item
  bltf_pkg::item_cmd_t              item_cmd_r;
  logic [bltf_pkg::PCT_W-1:0]       item_pct_r;
  logic [bltf_pkg::TICKS_W-1:0]     item_ticks_r;
  logic [bltf_pkg::ELAPSED_W-1:0]   item_elapsed_r;
  logic [bltf_pkg::PCT_W-1:0]       pct_sat;

  // light state
  bltf_pkg::mode_t                  mode_r, mode_nxt;
  logic [bltf_pkg::LEVEL_W-1:0]     level_r, level_nxt;
  logic [bltf_pkg::TICKS_W-1:0]     time_left_r, time_left_nxt;
  logic [bltf_pkg::FSTEP_W-1:0]     fade_step_r, fade_step_nxt;
  logic [bltf_pkg::PASS_W-1:0]      passes_r, passes_nxt;
  logic [bltf_pkg::PASS_W-1:0]      pass_dec;
  logic [bltf_pkg::LEVEL_W-1:0]     step_ext;
  logic [bltf_pkg::FADE_PROD_W-1:0] fade_prod;

  // result register
  logic                             out_valid_r;
  logic [bltf_pkg::LEVEL_W-1:0]     out_level_r;
  bltf_pkg::mode_t                  out_mode_r;

  // divider
  logic [bltf_pkg::LEVEL_W-1:0]     div_dividend;
  logic [bltf_pkg::PCT_W-1:0]       div_divisor;
  logic [bltf_pkg::LEVEL_W-1:0]     div_q;
  logic                             div_done;
  logic                             pct_zero;
  logic                             expire;

  assign pct_sat = (in_percent > bltf_pkg::PCT_W'(bltf_pkg::PCT_MAX))
                   ? bltf_pkg::PCT_W'(bltf_pkg::PCT_MAX) : in_percent;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_cmd_r     <= bltf_pkg::item_cmd_t'(in_command);
      item_pct_r     <= pct_sat;
      item_ticks_r   <= in_on_ticks;
      item_elapsed_r <= in_elapsed_ticks;
    end
  end

  assign pct_zero = (item_pct_r == '0);
  assign expire   = (bltf_pkg::TICKS_W'(item_elapsed_r) > time_left_r);

  // fade step = level / fade steps; the level never exceeds full level, so
  // the product fits and the quotient is exact
  assign fade_prod = bltf_pkg::FADE_PROD_W'(level_r)
                   * bltf_pkg::FADE_PROD_W'(bltf_pkg::FADE_RECIP);

  always_comb begin
    case (cmd.div_sel)
      bltf_pkg::DIV_LVL: begin
        div_dividend = bltf_pkg::LEVEL_W'(bltf_pkg::FULL_LEVEL);
        div_divisor  = div_q[bltf_pkg::PCT_W-1:0];  // 100/pct never exceeds 100
      end
      default: begin
        div_dividend = bltf_pkg::LEVEL_W'(bltf_pkg::PCT_MAX);
        div_divisor  = item_pct_r;
      end
    endcase
  end

  bltf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  // state update for the captured item
  always_comb begin
    mode_nxt      = mode_r;
    level_nxt     = level_r;
    time_left_nxt = time_left_r;
    fade_step_nxt = fade_step_r;
    passes_nxt    = passes_r;
    pass_dec      = passes_r - 1'b1;
    step_ext      = bltf_pkg::LEVEL_W'(fade_step_r);
    if (item_cmd_r == bltf_pkg::CMD_ON) begin
      mode_nxt      = bltf_pkg::MODE_ON;
      level_nxt     = pct_zero ? '0 : div_q;
      time_left_nxt = item_ticks_r;
      fade_step_nxt = '0;
      passes_nxt    = '0;
    end else begin
      case (mode_r)
        bltf_pkg::MODE_FADE: begin
          level_nxt  = (level_r >= step_ext) ? level_r - step_ext : '0;
          passes_nxt = pass_dec;
          if (pass_dec == '0) begin
            mode_nxt  = bltf_pkg::MODE_OFF;
            level_nxt = '0;
          end
        end
        bltf_pkg::MODE_ON: begin
          // level is unchanged while on: it was set from the same percent
          if (expire) begin
            mode_nxt      = bltf_pkg::MODE_FADE;
            time_left_nxt = '0;
            fade_step_nxt = fade_prod[bltf_pkg::FADE_PROD_W-1 -: bltf_pkg::FSTEP_W];
            passes_nxt    = bltf_pkg::PASS_W'(bltf_pkg::FADE_STEPS);
          end else begin
            time_left_nxt = time_left_r - bltf_pkg::TICKS_W'(item_elapsed_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= bltf_pkg::MODE_OFF;
      level_r     <= '0;
      time_left_r <= '0;
      fade_step_r <= '0;
      passes_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        mode_r      <= mode_nxt;
        level_r     <= level_nxt;
        time_left_r <= time_left_nxt;
        fade_step_r <= fade_step_nxt;
        passes_r    <= passes_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_level_r <= level_nxt;
      out_mode_r  <= mode_nxt;
    end
  end

  always_comb begin
    sts.on_req   = (item_cmd_r == bltf_pkg::CMD_ON);
    sts.pct_zero = pct_zero;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_pwm_level = out_level_r;
  assign out_mode      = out_mode_r;

endmodule

`default_nettype wire

// File: src/bltf_ctrl.sv
// ----------------------------------------------------------------------------
// bltf_ctrl - backlight controller sequencer
// Takes one item at a time and steps the datapath through its divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module bltf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire bltf_pkg::ctl_sts_t  sts,
  output bltf_pkg::ctl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_DIV_A  = 3'd2,
    S_DIV_B  = 3'd3,
    S_APPLY  = 3'd4
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;

  always_comb begin
    state_nxt     = state_r;
    cmd.capture   = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_sel   = bltf_pkg::DIV_PCT;
    cmd.commit    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.on_req && !sts.pct_zero) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = bltf_pkg::DIV_PCT;
          state_nxt     = S_DIV_A;
        end else begin
          state_nxt = S_APPLY;
        end
      end
      S_DIV_A: begin
        if (sts.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = bltf_pkg::DIV_LVL;
          state_nxt     = S_DIV_B;
        end
      end
      S_DIV_B: begin
        cmd.div_sel = bltf_pkg::DIV_LVL;
        if (sts.div_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ready_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = ready_r;

endmodule

`default_nettype wire

// File: src/backlight_timeout_fade_controller_unit.sv
// ----------------------------------------------------------------------------
// backlight_timeout_fade_controller_unit - backlight PWM level controller
// Off / on / fade backlight level sequencing driven by tick and on items.
// ----------------------------------------------------------------------------
// Takes one item at a time and returns one result item per input item.
// An on request (command 1) saturates the percent at 100 and sets the PWM
// level to 8499 / (100 / pct), zero for pct 0, then arms the on time. A tick
// (command 0) counts elapsed_ticks off the on time; the tick that overruns it
// switches to fade and takes the per-pass step as level / 50 (a constant
// reciprocal multiply). Each later tick subtracts that step (floored at 0)
// and after 50 passes the light goes off at level 0. An on request restarts
// the on period in any mode. An on request with a non-zero percent runs
// the one shared restoring divider twice, one quotient bit per cycle over
// 14 bits; every other item skips it. The next item is taken the cycle
// after the result is registered. A waiting result does not stall the next
// item's work, only its final write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module backlight_timeout_fade_controller_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bltf_in_if.sink     in_ch,
  bltf_out_if.source  out_ch
);

  bltf_pkg::ctl_cmd_t ctl_cmd;
  bltf_pkg::ctl_sts_t ctl_sts;

  // sequencer: item intake and division steps
  bltf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (ctl_sts),
    .cmd      (ctl_cmd)
  );

  // datapath: light state, divider, result register
  bltf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (ctl_cmd),
    .sts               (ctl_sts),
    .in_command        (in_ch.command),
    .in_percent        (in_ch.percent),
    .in_on_ticks       (in_ch.on_ticks),
    .in_elapsed_ticks  (in_ch.elapsed_ticks),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_pwm_level     (out_ch.pwm_level),
    .out_mode          (out_ch.mode)
  );

  // a result is only written into a free output slot
  a_commit_slot_free: assert property (
    @(posedge clk) disable iff (!rst_n)
    ctl_cmd.commit |-> ctl_sts.out_free
  ) else $error("result written over an untaken result");

  // one item at a time: intake closes after an accept
  a_one_item: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready
  ) else $error("second item accepted while one is in progress");

  // the light is dark whenever it is reported off
  a_off_dark: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.mode == bltf_pkg::MODE_OFF) |-> (out_ch.pwm_level == '0)
  ) else $error("non-zero level reported in off mode");

endmodule

`default_nettype wire

// File: dv/bltf_level_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bltf_level_checker - result checker for the backlight fade controller
// Watches both item channels, predicts level and mode for every accepted
// input item and compares each accepted result item against the oldest one.
// ----------------------------------------------------------------------------

module bltf_level_checker
  import bltf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bltf_in_if   in_mon,
  bltf_out_if  out_mon,
  output int   fail_count,
  output int   pending_count
);

  typedef struct packed {
    logic [LEVEL_W-1:0] pwm_level;
    mode_t              mode;
  } light_result_t;

  light_result_t expected_light_q[$];

  // predicted controller state
  mode_t              pred_mode;
  logic [LEVEL_W-1:0] pred_level;
  logic [PCT_W-1:0]   pred_pct;
  logic [TICKS_W:0]   pred_time_left;
  logic [FSTEP_W-1:0] pred_fade_step;
  logic [PASS_W-1:0]  pred_passes_left;

  int errs;

  function automatic logic [LEVEL_W-1:0] level_for_percent(input logic [PCT_W-1:0] pct);
    int unsigned p;
    int unsigned divisor;
    p = pct;
    if (p == 0) return '0;
    if (p > PCT_MAX) p = PCT_MAX;
    divisor = PCT_MAX / p;
    return LEVEL_W'(FULL_LEVEL / divisor);
  endfunction

  task automatic predict_light_result(input item_cmd_t cmd,
                                      input logic [PCT_W-1:0] pct,
                                      input logic [TICKS_W-1:0] ticks,
                                      input logic [ELAPSED_W-1:0] elapsed);
    light_result_t res;
    logic [PCT_W-1:0] sat_pct;
    sat_pct = (pct > PCT_MAX) ? PCT_W'(PCT_MAX) : pct;
    if (cmd == CMD_ON) begin
      pred_pct         = sat_pct;
      pred_level       = level_for_percent(sat_pct);
      pred_time_left   = {1'b0, ticks};
      pred_fade_step   = '0;
      pred_passes_left = '0;
      pred_mode        = MODE_ON;
    end else if (pred_mode == MODE_FADE) begin
      if (pred_level >= LEVEL_W'(pred_fade_step))
        pred_level = pred_level - LEVEL_W'(pred_fade_step);
      else
        pred_level = '0;
      pred_passes_left = pred_passes_left - 1'b1;
      if (pred_passes_left == 0) begin
        pred_mode  = MODE_OFF;
        pred_level = '0;
      end
    end else if (pred_mode == MODE_ON) begin
      pred_level = level_for_percent(pred_pct);
      if ({7'd0, elapsed} > pred_time_left) begin
        pred_time_left   = '0;
        pred_mode        = MODE_FADE;
        pred_fade_step   = FSTEP_W'(pred_level / FADE_STEPS);
        pred_passes_left = PASS_W'(FADE_STEPS);
      end else begin
        pred_time_left = pred_time_left - {7'd0, elapsed};
      end
    end
    res.pwm_level = pred_level;
    res.mode      = pred_mode;
    expected_light_q.push_back(res);
  endtask

  always @(posedge clk) begin
    light_result_t exp_res;
    if (!rst_n) begin
      expected_light_q.delete();
      pred_mode        = MODE_OFF;
      pred_level       = '0;
      pred_pct         = '0;
      pred_time_left   = '0;
      pred_fade_step   = '0;
      pred_passes_left = '0;
      errs             = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_light_q.size() == 0) begin
          $display("%0t: result item with none expected: level %0d mode %0d",
                   $time, out_mon.pwm_level, out_mon.mode);
          errs++;
        end else begin
          exp_res = expected_light_q.pop_front();
          if (out_mon.pwm_level !== exp_res.pwm_level) begin
            $display("%0t: pwm_level mismatch, expected %0d, actual %0d",
                     $time, exp_res.pwm_level, out_mon.pwm_level);
            errs++;
          end
          if (out_mon.mode !== exp_res.mode) begin
            $display("%0t: mode mismatch, expected %0d, actual %0d",
                     $time, exp_res.mode, out_mon.mode);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_light_result(item_cmd_t'(in_mon.command), in_mon.percent,
                             in_mon.on_ticks, in_mon.elapsed_ticks);
    end
    fail_count    <= errs;
    pending_count <= expected_light_q.size();
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench top for the backlight timeout/fade controller
// Drives directed and random on/tick items with random idling on both
// channels, including one long output hold-off, and reports the verdict
// from the checker's failure and outstanding counts.
// ----------------------------------------------------------------------------

module tb_top;
  import bltf_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int TARGET_ITEMS  = 550;
  localparam int HOLD_AT       = 120;   // result count at which the long hold-off starts
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 40;

  logic clk = 1'b0;
  logic rst_n;

  int fail_count;
  int pending_count;
  int cycle_count = 0;

  // stimulus bookkeeping
  int on_sent   = 0;
  int tick_sent = 0;
  int seq_count = 0;
  bit src_burst = 1'b0;   // sender runs back to back while set
  bit snk_burst = 1'b0;   // receiver never stalls while set
  int results   = 0;

  bltf_in_if  in_ch();
  bltf_out_if out_ch();

  backlight_timeout_fade_controller_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bltf_level_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  // Watchdog: ends a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one item. Called at the edge where the previous item was taken
  // (or after reset); valid is only lowered when a gap is drawn, so it never
  // gets two updates in one step.
  task automatic send_item(input item_cmd_t cmd, input logic [PCT_W-1:0] pct,
                           input logic [TICKS_W-1:0] ticks,
                           input logic [ELAPSED_W-1:0] elapsed);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= cmd;
    in_ch.percent        <= pct;
    in_ch.on_ticks       <= ticks;
    in_ch.elapsed_ticks  <= elapsed;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_ON) on_sent++;
    else tick_sent++;
  endtask

  // Tick item: percent and on time are don't-care, so fill them at random.
  task automatic send_tick(input logic [ELAPSED_W-1:0] elapsed);
    send_item(CMD_TICK, PCT_W'($urandom), TICKS_W'($urandom), elapsed);
  endtask

  // Elapsed time for a tick: mostly uniform, with the extremes weighted up.
  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ELAPSED_W'($urandom_range(0, 1023));
  endfunction

  // Result side: random stall per item, stall-free stretches and one long
  // hold-off so that the block backs up and stalls its input.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (results == HOLD_AT) hold = HOLD_CYCLES;
      else hold = snk_burst ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      results++;
      if ($urandom_range(0, 24) == 0) snk_burst = ~snk_burst;
    end
  end

  initial begin
    int n_ticks;
    int r;
    logic [PCT_W-1:0]   pct;
    logic [TICKS_W-1:0] on_time;

    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.command        = CMD_TICK;
    in_ch.percent        = '0;
    in_ch.on_ticks       = '0;
    in_ch.elapsed_ticks  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    send_item(CMD_TICK, 7'd127, 16'hFFFF, 10'd1023);  // tick while off: no change
    send_item(CMD_ON,   7'd0,   16'd0,    10'd1023);  // zero percent gives level 0
    send_tick(10'd0);                                 // zero elapsed, still on
    send_tick(10'd1);                                 // overrun: fade with zero step
    send_tick(10'd0);                                 // fade pass at level 0
    send_item(CMD_ON,   7'd127, 16'hFFFF, 10'd0);     // above 100 saturates, longest on
    send_tick(10'd1023);
    send_item(CMD_ON,   7'd100, 16'd0,    10'd1023);  // full level, elapsed ignored
    send_tick(10'd0);
    send_tick(10'd1);                                 // expiry, step is level / 50
    send_tick(10'd1023);                              // first subtraction
    send_tick(10'd0);
    send_item(CMD_ON,   7'd1,   16'd2,    10'd0);     // restart during fade
    send_tick(10'd2);                                 // equal to remaining: stays on
    send_tick(10'd1);                                 // now overruns
    send_item(CMD_ON,   7'd101, 16'd7,    10'd0);
    send_item(CMD_ON,   7'd33,  16'h5555, 10'h2AA);
    send_item(CMD_ON,   7'd50,  16'hAAAA, 10'h155);
    send_item(CMD_ON,   7'd99,  16'd1,    10'd0);
    send_item(CMD_ON,   7'd51,  16'd3,    10'd0);
    send_item(CMD_ON,   7'd34,  16'd0,    10'd0);
    send_tick(10'h2AA);
    send_tick(10'h155);

    // --- random part: mostly on request followed by a run of ticks, which
    // either runs out through the whole fade or is cut short by the next
    // request; a share of pure noise items in between ---
    while (on_sent + tick_sent < TARGET_ITEMS) begin
      src_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        r = $urandom_range(0, 1);
        send_item(item_cmd_t'(r), PCT_W'($urandom), TICKS_W'($urandom),
                  ELAPSED_W'($urandom));
      end else begin
        seq_count++;
        r = $urandom_range(0, 7);
        if (r == 0)      pct = '0;
        else if (r == 1) pct = PCT_W'(PCT_MAX);
        else if (r == 2) pct = PCT_W'($urandom_range(101, 127));
        else             pct = PCT_W'($urandom_range(1, 100));
        if ($urandom_range(0, 5) == 0) on_time = TICKS_W'($urandom);
        else on_time = TICKS_W'($urandom_range(0, 4000));
        send_item(CMD_ON, pct, on_time, ELAPSED_W'($urandom));
        n_ticks = $urandom_range(4, 70);
        if (n_ticks > TARGET_ITEMS - on_sent - tick_sent)
          n_ticks = TARGET_ITEMS - on_sent - tick_sent;
        repeat (n_ticks) begin
          send_tick(pick_elapsed());
        end
      end
    end

    // drain
    src_burst = 1'b0;
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d on requests and %0d ticks in %0d on/fade sequences,",
             on_sent, tick_sent, seq_count);
    $display("with random idling both sides and one %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
src/bltf_pkg.sv
src/bltf_if.sv
src/bltf_div.sv
src/bltf_dp.sv
src/bltf_ctrl.sv
src/backlight_timeout_fade_controller_unit.sv
dv/bltf_level_checker.sv
dv/tb_top.sv
